@@ rtl/core/sfs_pkg.sv @@
// Package for the slot allocator with a LIFO free stack.
// Holds the request and response types, the pool size and the operation and status codes.
// Depends on nothing.
`default_nettype none

package sfs_pkg;

  localparam int unsigned POOL_SIZE = 64;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned LIVE_W   = 7;

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_GRANTED = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_FREED   = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_DEAD    = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_ABOVE   = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_CLEARED = 3'd5;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [SLOT_W-1:0] slot_id;
  } sfs_req_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   granted_slot;
    logic [STATUS_W-1:0] status;
    logic [LIVE_W-1:0]   live_count;
  } sfs_rsp_t;

endpackage

`default_nettype wire

@@ rtl/core/sfs_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Used for the free stack; depends on nothing.
`default_nettype none

module sfs_ram #(
  parameter int unsigned WIDTH = 6,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ rtl/core/slot_allocator_free_stack_top.sv @@
// Slot allocator with a LIFO free stack; uses sfs_pkg and sfs_ram.
// The result strobe is registered and comes in the cycle after the transfer of a request.
// Throughput: one request per cycle; busy stays low because the top of the
// stack is prefetched from the stack RAM every cycle, with a write bypass.
// Reset clears the counters and the live flags; the stack RAM is not cleared.
// The receiver cannot stall, so every result is presented for one cycle only.
`default_nettype none

module slot_allocator_free_stack_top (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire sfs_pkg::sfs_req_t req_i,
  output logic                  done_o,
  output sfs_pkg::sfs_rsp_t     rsp_o
);

  import sfs_pkg::*;

  localparam int unsigned IDX_W = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int unsigned CNT_W = $clog2(POOL_SIZE + 1);
  localparam int unsigned EXT_W = (CNT_W > LIVE_W) ? CNT_W : LIVE_W;

  logic [CNT_W-1:0]     depth_q, depth_d;
  logic [CNT_W-1:0]     mark_q, mark_d;
  logic [POOL_SIZE-1:0] live_q, live_d;
  logic                 done_q, done_d;
  logic                 bypass_q, bypass_d;
  logic [IDX_W-1:0]     bypass_data_q;
  sfs_rsp_t             rsp_q, rsp_d;

  logic                 we;
  logic [IDX_W-1:0]     waddr;
  logic [IDX_W-1:0]     raddr;
  logic [IDX_W-1:0]     ram_rdata;
  logic [IDX_W-1:0]     top_data;
  logic [IDX_W-1:0]     slot;
  logic [IDX_W-1:0]     id_idx;
  logic [EXT_W-1:0]     id_ext;
  logic [EXT_W-1:0]     slot_ext;
  logic [EXT_W-1:0]     live_ext;
  logic [CNT_W-1:0]     live_cnt;
  logic [CNT_W-1:0]     depth_m1;
  logic [STATUS_W-1:0]  status;
  logic                 accept;

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign id_ext   = EXT_W'(req_i.slot_id);
  assign id_idx   = id_ext[IDX_W-1:0];
  assign top_data = bypass_q ? bypass_data_q : ram_rdata;
  assign waddr    = depth_q[IDX_W-1:0];

  always_comb begin
    depth_d = depth_q;
    mark_d  = mark_q;
    live_d  = live_q;
    we      = 1'b0;
    slot    = '0;
    status  = STAT_DEAD;
    done_d  = accept;
    if (accept) begin
      case (req_i.op)
        OP_ALLOC: begin
          if (depth_q != '0) begin
            depth_d = depth_q - 1'b1;
            slot    = top_data;
            live_d[slot] = 1'b1;
            status  = STAT_GRANTED;
          end else if (mark_q < CNT_W'(POOL_SIZE)) begin
            slot    = mark_q[IDX_W-1:0];
            mark_d  = mark_q + 1'b1;
            live_d[slot] = 1'b1;
            status  = STAT_GRANTED;
          end else begin
            status  = STAT_FULL;
          end
        end
        OP_FREE: begin
          if (id_ext >= EXT_W'(mark_q)) begin
            status = STAT_ABOVE;
          end else if (!live_q[id_idx]) begin
            status = STAT_DEAD;
          end else begin
            live_d[id_idx] = 1'b0;
            we      = 1'b1;
            depth_d = depth_q + 1'b1;
            if (depth_d == CNT_W'(POOL_SIZE)) begin
              depth_d = '0;
              mark_d  = '0;
            end
            status  = STAT_FREED;
          end
        end
        OP_CLEAR: begin
          depth_d = '0;
          mark_d  = '0;
          live_d  = '0;
          status  = STAT_CLEARED;
        end
        default: begin
          status = STAT_DEAD;
        end
      endcase
    end
  end

  assign depth_m1 = depth_d - 1'b1;
  assign raddr    = (depth_d == '0) ? '0 : depth_m1[IDX_W-1:0];
  assign bypass_d = we && (waddr == raddr);

  assign live_cnt = mark_d - depth_d;
  assign live_ext = EXT_W'(live_cnt);
  assign slot_ext = EXT_W'(slot);

  always_comb begin
    rsp_d              = rsp_q;
    if (accept) begin
      rsp_d.granted_slot = slot_ext[SLOT_W-1:0];
      rsp_d.status       = status;
      rsp_d.live_count   = live_ext[LIVE_W-1:0];
    end
  end

  sfs_ram #(
    .WIDTH (IDX_W),
    .DEPTH (POOL_SIZE)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (id_idx),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q  <= '0;
      mark_q   <= '0;
      live_q   <= '0;
      done_q   <= 1'b0;
      bypass_q <= 1'b0;
    end else begin
      depth_q  <= depth_d;
      mark_q   <= mark_d;
      live_q   <= live_d;
      done_q   <= done_d;
      bypass_q <= bypass_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q         <= rsp_d;
    bypass_data_q <= id_idx;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

`default_nettype wire
